/* src/pedal_plausibility_fault_monitor_assert.svh */
// Assertion macros shared by the pedal plausibility monitor RTL.
`ifndef PEDAL_PLAUSIBILITY_FAULT_MONITOR_ASSERT_SVH
`define PEDAL_PLAUSIBILITY_FAULT_MONITOR_ASSERT_SVH

`ifndef SYNTH
// Clocked assertion that is switched off while reset is asserted.
`define PPFM_ASSERT(lbl, clock, rstn, prop) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) prop) \
		else $error("%m: assertion failed");
// Clocked assertion that is also checked during reset.
`define PPFM_ASSERT_ALWAYS(lbl, clock, prop) \
	lbl: assert property (@(posedge clock) prop) \
		else $error("%m: assertion failed");
`else
`define PPFM_ASSERT(lbl, clock, rstn, prop)
`define PPFM_ASSERT_ALWAYS(lbl, clock, prop)
`endif

`endif

/* src/pdlpl_pkg.sv */
// Types, register indexes and constants of the pedal plausibility monitor.
package pdlpl_pkg;

	localparam int unsigned SAMPLE_W   = 10;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned FAULT_W    = 5;
	localparam int unsigned SHUTDOWN_CODES = 10;
	localparam int unsigned NUM_FLAGS  = 6;

	localparam logic [FAULT_W-1:0] ALL_OK_CODE = 5'd16;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEVIATION          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX              = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN              = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_ON_LEVEL         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_QUARTER_LEVEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_FIVE_OFFSET   = 3'd5;

	localparam logic [SAMPLE_W-1:0] RST_MAX_DEVIATION          = 10'd102;
	localparam logic [SAMPLE_W-1:0] RST_RANGE_MAX              = 10'd1000;
	localparam logic [SAMPLE_W-1:0] RST_RANGE_MIN              = 10'd20;
	localparam logic [SAMPLE_W-1:0] RST_BRAKE_ON_LEVEL         = 10'd200;
	localparam logic [SAMPLE_W-1:0] RST_THROTTLE_QUARTER_LEVEL = 10'd256;
	localparam logic [SAMPLE_W-1:0] RST_THROTTLE_FIVE_OFFSET   = 10'd51;

	typedef struct packed {
		logic [SAMPLE_W-1:0] throttle_one;
		logic [SAMPLE_W-1:0] throttle_two;
		logic [SAMPLE_W-1:0] brake_level;
		logic [SAMPLE_W-1:0] shutdown_bits;
	} sample_t;

	typedef struct packed {
		logic               agree_ok;
		logic               throttle_one_range_ok;
		logic               throttle_two_range_ok;
		logic               brake_range_ok;
		logic               brake_throttle_ok;
		logic               reactivate_ok;
		logic               pedal_ok;
		logic [FAULT_W-1:0] first_fault;
	} result_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] max_deviation;
		logic [SAMPLE_W-1:0] range_max;
		logic [SAMPLE_W-1:0] range_min;
		logic [SAMPLE_W-1:0] brake_on_level;
		logic [SAMPLE_W-1:0] throttle_quarter_level;
		logic [SAMPLE_W-1:0] throttle_five_offset;
	} cfg_t;

endpackage

/* src/pdlpl_cfg_regs.sv */
// Configuration register file of the pedal plausibility monitor.
module pdlpl_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [pdlpl_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [pdlpl_pkg::SAMPLE_W-1:0]  wr_data,
	output pdlpl_pkg::cfg_t                 cfg
);

	pdlpl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_deviation          <= pdlpl_pkg::RST_MAX_DEVIATION;
			cfg_q.range_max              <= pdlpl_pkg::RST_RANGE_MAX;
			cfg_q.range_min              <= pdlpl_pkg::RST_RANGE_MIN;
			cfg_q.brake_on_level         <= pdlpl_pkg::RST_BRAKE_ON_LEVEL;
			cfg_q.throttle_quarter_level <= pdlpl_pkg::RST_THROTTLE_QUARTER_LEVEL;
			cfg_q.throttle_five_offset   <= pdlpl_pkg::RST_THROTTLE_FIVE_OFFSET;
		end else if (wr_en) begin
			case (wr_index)
				pdlpl_pkg::CFG_MAX_DEVIATION:          cfg_q.max_deviation <= wr_data;
				pdlpl_pkg::CFG_RANGE_MAX:              cfg_q.range_max <= wr_data;
				pdlpl_pkg::CFG_RANGE_MIN:              cfg_q.range_min <= wr_data;
				pdlpl_pkg::CFG_BRAKE_ON_LEVEL:         cfg_q.brake_on_level <= wr_data;
				pdlpl_pkg::CFG_THROTTLE_QUARTER_LEVEL: cfg_q.throttle_quarter_level <= wr_data;
				pdlpl_pkg::CFG_THROTTLE_FIVE_OFFSET:   cfg_q.throttle_five_offset <= wr_data;
				default: begin
					// Writes to unused indexes are dropped.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/pdlpl_eval.sv */
// Plausibility checks, reactivation latch and fault priority encoder.
module pdlpl_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  pdlpl_pkg::sample_t sample,
	input  pdlpl_pkg::cfg_t    cfg,
	output pdlpl_pkg::result_t result
);

	logic                            latch_q;
	logic                            latch_d;
	logic                            latch_mid;
	logic [pdlpl_pkg::SAMPLE_W-1:0]  diff;
	logic [pdlpl_pkg::SAMPLE_W:0]    level;
	logic [pdlpl_pkg::SAMPLE_W:0]    t1_ext;
	logic                            conflict;
	logic                            react;
	logic [pdlpl_pkg::NUM_FLAGS-1:0] flags;
	logic [pdlpl_pkg::FAULT_W-1:0]   fault;

	always_comb begin
		if (sample.throttle_one > sample.throttle_two) begin
			diff = sample.throttle_one - sample.throttle_two;
		end else begin
			diff = sample.throttle_two - sample.throttle_one;
		end

		flags[0] = (diff <= cfg.max_deviation);
		flags[1] = (sample.throttle_one <= cfg.range_max) &&
			(sample.throttle_one >= cfg.range_min);
		flags[2] = (sample.throttle_two <= cfg.range_max) &&
			(sample.throttle_two >= cfg.range_min);
		flags[3] = (sample.brake_level <= cfg.range_max) &&
			(sample.brake_level >= cfg.range_min);

		conflict = (sample.brake_level > cfg.brake_on_level) &&
			(sample.throttle_one > cfg.throttle_quarter_level);
		flags[4] = !conflict;
		latch_mid = conflict ? 1'b0 : latch_q;

		// The reactivation level is an 11-bit sum and never wraps.
		level  = {1'b0, cfg.range_min} + {1'b0, cfg.throttle_five_offset};
		t1_ext = {1'b0, sample.throttle_one};
		if (t1_ext < level) begin
			latch_d = 1'b1;
			react   = 1'b1;
		end else if ((t1_ext > level) && !latch_mid) begin
			latch_d = latch_mid;
			react   = 1'b0;
		end else begin
			latch_d = latch_mid;
			react   = 1'b1;
		end
		flags[5] = react & flags[4];

		// Lowest failing code wins: shutdown bits first, then the pedal flags.
		fault = pdlpl_pkg::ALL_OK_CODE;
		for (int i = pdlpl_pkg::NUM_FLAGS - 1; i >= 0; i--) begin
			if (!flags[i]) begin
				fault = pdlpl_pkg::FAULT_W'(pdlpl_pkg::SHUTDOWN_CODES + i);
			end
		end
		for (int i = pdlpl_pkg::SHUTDOWN_CODES - 1; i >= 0; i--) begin
			if (!sample.shutdown_bits[i]) begin
				fault = pdlpl_pkg::FAULT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 1'b1;
		end else if (en) begin
			latch_q <= latch_d;
		end
	end

	assign result.agree_ok              = flags[0];
	assign result.throttle_one_range_ok = flags[1];
	assign result.throttle_two_range_ok = flags[2];
	assign result.brake_range_ok        = flags[3];
	assign result.brake_throttle_ok     = flags[4];
	assign result.reactivate_ok         = flags[5];
	assign result.pedal_ok              = &flags;
	assign result.first_fault           = fault;

endmodule

/* src/pedal_plausibility_fault_monitor.sv */
// Pedal plausibility and shutdown-loop fault monitor, top level.
//
// Sample channel: sample_valid / sample_stall carry one sample set per
// transaction (two throttle readings, brake reading, ten shutdown bits).
// Result channel: result_valid / result_stall carry the six pass flags, the
// overall pedal pass and the first failing code (16 when all is well).
// Configuration: cfg_valid / cfg_ready write cfg_data into register
// cfg_index; cfg_ready is always high and unknown indexes are ignored.
// An accepted sample goes to the input register, its result to the result
// register. Throughput is one sample per cycle unless the receiver stalls:
// the input register and the result register form a two-deep pipeline,
// and the checks plus the reactivation latch update sit in one short stage
// between them. When the receiver stalls, the result holds and one more
// sample is taken into the input register; sample_stall rises only when both
// are full. Reset clears both valid bits, loads the register defaults and
// sets the reactivation latch, so throttle may drive right after reset.
module pedal_plausibility_fault_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  pdlpl_pkg::sample_t              sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output pdlpl_pkg::result_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pdlpl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pdlpl_pkg::SAMPLE_W-1:0]  cfg_data
);

	`include "pedal_plausibility_fault_monitor_assert.svh"

	pdlpl_pkg::cfg_t    cfg;
	pdlpl_pkg::sample_t sample_s1;
	pdlpl_pkg::result_t result_d;
	pdlpl_pkg::result_t result_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               advance;
	logic               accept;

	assign cfg_ready = 1'b1;

	pdlpl_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The stage moves forward whenever the result register is free or drains.
	assign advance      = valid_s1 && (!valid_s2 || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & ~advance);
			valid_s2 <= advance | (valid_s2 & result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	pdlpl_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.sample (sample_s1),
		.cfg    (cfg),
		.result (result_d)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// A sample waiting in the input register is neither dropped nor altered.
	`PPFM_ASSERT(a_s1_held, clk, arst_n, (valid_s1 && !advance) |=> (valid_s1 && $stable(sample_s1)))
	// A clean code means every pedal flag passed.
	`PPFM_ASSERT(a_all_ok_pedal, clk, arst_n, (valid_s2 && (result_s2.first_fault == pdlpl_pkg::ALL_OK_CODE)) |-> result_s2.pedal_ok)
	// A pedal fault code means the pedal pass is low.
	`PPFM_ASSERT(a_pedal_code, clk, arst_n, (valid_s2 && (result_s2.first_fault >= pdlpl_pkg::FAULT_W'(pdlpl_pkg::SHUTDOWN_CODES)) && (result_s2.first_fault < pdlpl_pkg::ALL_OK_CODE)) |-> !result_s2.pedal_ok)
	// Reactivation can only pass when brake and throttle do not conflict.
	`PPFM_ASSERT(a_react_needs_bt, clk, arst_n, (valid_s2 && result_s2.reactivate_ok) |-> result_s2.brake_throttle_ok)
	// Right after reset is seen low, neither result_valid nor sample_stall is high.
	`PPFM_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> (!result_valid && !sample_stall))

endmodule
